// ----- design/eads_pkg.sv -----
// Package for the enemy-aware disjoint-set engine.
// Holds the op and status codes, the controller states and the controller/datapath command types.
// It has no dependencies.
`default_nettype none
package eads_pkg;

	localparam int unsigned MaxPeopleDefault = 65536;
	localparam int unsigned CountW = 17;
	localparam int unsigned PersonW = 16;
	localparam int unsigned RankW = 5;
	localparam logic [RankW-1:0] RankMax = 5'd31;
	localparam logic [CountW-1:0] CountReset = 17'h10000;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_DECLARE = 2'd1,
		OP_ASK     = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_DONE   = 3'd0,
		STAT_SAME   = 3'd1,
		STAT_DIFF   = 3'd2,
		STAT_UNSURE = 3'd3,
		STAT_BAD    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_CHECK,
		S_WALK,
		S_COMP,
		S_LINK1,
		S_LINK2,
		S_LNEXT,
		S_REPLY
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CAPTURE,
		DP_CLEAR,
		DP_LOAD,
		DP_FOLLOW,
		DP_ROOT,
		DP_COMPRESS,
		DP_LINK1,
		DP_LINK2
	} dp_op_t;

	typedef enum logic [1:0] {
		NODE_A,
		NODE_B,
		NODE_AC,
		NODE_BC
	} node_sel_t;

	typedef struct packed {
		dp_op_t    op;
		node_sel_t node;
		logic      save_ry;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_root;
		logic comp_done;
		logic roots_eq;
		logic clr_last;
		logic bad;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- design/eads_dp.sv -----
// Datapath of the enemy-aware disjoint-set engine: node memory, walk pointer, saved roots.
// Depends on eads_pkg; driven by eads_ctrl through command and status structs.
`default_nettype none
module eads_dp #(
	parameter int unsigned MAX_PEOPLE = eads_pkg::MaxPeopleDefault
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire eads_pkg::dp_cmd_t             cmd,
	output eads_pkg::dp_stat_t                 stat,
	input  wire logic [eads_pkg::PersonW-1:0]  person_a,
	input  wire logic [eads_pkg::PersonW-1:0]  person_b,
	input  wire logic [eads_pkg::CountW-1:0]   people_count
);
	localparam int unsigned NodeCount = 2 * MAX_PEOPLE;
	localparam int unsigned NodeW = $clog2(NodeCount);
	localparam int unsigned CntW = $clog2(MAX_PEOPLE + 1);
	localparam int unsigned RkW = eads_pkg::RankW;
	localparam int unsigned WordW = RkW + NodeW;

	// Each word holds {rank, parent}.
	logic [WordW-1:0] mem [NodeCount];
	logic [WordW-1:0] rdata_q;

	logic [eads_pkg::PersonW-1:0] a_q, b_q;
	logic [NodeW-1:0] cur_q, cur_d, root_q, rx_q, ry_q, clr_q, node;
	logic [RkW-1:0] rk_rx_q, rk_ry_q, rk_inc;
	logic [CntW-1:0] count_eff;
	logic [NodeW-1:0] rd_parent;
	logic [RkW-1:0] rd_rank;
	logic we;
	logic [NodeW-1:0] waddr;
	logic [WordW-1:0] wdata;

	assign rd_parent = rdata_q[NodeW-1:0];
	assign rd_rank = rdata_q[WordW-1:NodeW];
	assign rk_inc = (rk_rx_q == eads_pkg::RankMax) ? rk_rx_q : rk_rx_q + 1'b1;

	assign count_eff = (32'(people_count) > MAX_PEOPLE) ? CntW'(MAX_PEOPLE) : CntW'(people_count);

	always_comb begin
		case (cmd.node)
			eads_pkg::NODE_A:  node = NodeW'(a_q);
			eads_pkg::NODE_B:  node = NodeW'(b_q);
			eads_pkg::NODE_AC: node = NodeW'(a_q) + NodeW'(count_eff);
			eads_pkg::NODE_BC: node = NodeW'(b_q) + NodeW'(count_eff);
			default:           node = NodeW'(a_q);
		endcase
	end

	always_comb begin
		cur_d = cur_q;
		we = 1'b0;
		waddr = clr_q;
		wdata = {RkW'(0), clr_q};
		case (cmd.op)
			eads_pkg::DP_CLEAR: we = 1'b1;
			eads_pkg::DP_LOAD, eads_pkg::DP_ROOT: cur_d = node;
			eads_pkg::DP_FOLLOW: cur_d = rd_parent;
			eads_pkg::DP_COMPRESS: begin
				we = 1'b1;
				waddr = cur_q;
				wdata = {rd_rank, root_q};
				cur_d = rd_parent;
			end
			eads_pkg::DP_LINK1: begin
				we = 1'b1;
				if (rk_rx_q < rk_ry_q) begin
					waddr = rx_q;
					wdata = {rk_rx_q, ry_q};
				end else begin
					waddr = ry_q;
					wdata = {rk_ry_q, rx_q};
				end
			end
			eads_pkg::DP_LINK2: begin
				we = (rk_rx_q == rk_ry_q);
				waddr = rx_q;
				wdata = {rk_inc, rx_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[cur_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cur_q <= '0;
		end else begin
			cur_q <= cur_d;
			if (cmd.op == eads_pkg::DP_CAPTURE) begin
				clr_q <= '0;
			end else if (cmd.op == eads_pkg::DP_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == eads_pkg::DP_CAPTURE) begin
			a_q <= person_a;
			b_q <= person_b;
		end
		if (cmd.op == eads_pkg::DP_ROOT) begin
			root_q <= cur_q;
			if (cmd.save_ry) begin
				ry_q <= cur_q;
				rk_ry_q <= rd_rank;
			end else begin
				rx_q <= cur_q;
				rk_rx_q <= rd_rank;
			end
		end
	end

	assign stat.walk_root = (rd_parent == cur_q);
	assign stat.comp_done = (cur_q == root_q);
	assign stat.roots_eq = (rx_q == ry_q);
	assign stat.clr_last = (32'(clr_q) == NodeCount - 1);
	assign stat.bad = (32'(a_q) >= 32'(count_eff)) || (32'(b_q) >= 32'(count_eff));

endmodule
`default_nettype wire

// ----- design/eads_ctrl.sv -----
// Controller state machine of the enemy-aware disjoint-set engine.
// Depends on eads_pkg; steers eads_dp through command and status structs.
`default_nettype none
module eads_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [1:0]           op,
	output logic                      busy,
	output logic                      done,
	output logic [2:0]                status,
	output eads_pkg::dp_cmd_t         cmd,
	input  wire eads_pkg::dp_stat_t   stat
);
	eads_pkg::state_t state_q, state_d;
	eads_pkg::op_t op_q, op_d;
	eads_pkg::status_t status_q, status_d;
	logic [1:0] phase_q, phase_d;
	logic reply_q, reply_d;
	logic load_next;

	// Node walked in each phase: declare a, b+n, a+n, b; ask a, b, b+n.
	function automatic eads_pkg::node_sel_t node_of(eads_pkg::op_t o, logic [1:0] ph);
		eads_pkg::node_sel_t n;
		n = eads_pkg::NODE_A;
		if (o == eads_pkg::OP_DECLARE) begin
			case (ph)
				2'd0: n = eads_pkg::NODE_A;
				2'd1: n = eads_pkg::NODE_BC;
				2'd2: n = eads_pkg::NODE_AC;
				default: n = eads_pkg::NODE_B;
			endcase
		end else begin
			case (ph)
				2'd0: n = eads_pkg::NODE_A;
				2'd1: n = eads_pkg::NODE_B;
				default: n = eads_pkg::NODE_BC;
			endcase
		end
		return n;
	endfunction

	// Next state and sequencing registers.
	always_comb begin
		state_d = state_q;
		op_d = op_q;
		status_d = status_q;
		phase_d = phase_q;
		reply_d = reply_q;
		load_next = 1'b0;
		case (state_q)
			eads_pkg::S_IDLE: begin
				if (start) begin
					op_d = eads_pkg::op_t'(op);
					status_d = eads_pkg::STAT_DONE;
					case (eads_pkg::op_t'(op))
						eads_pkg::OP_CLEAR: begin
							reply_d = 1'b1;
							state_d = eads_pkg::S_CLEAR;
						end
						eads_pkg::OP_DECLARE, eads_pkg::OP_ASK: state_d = eads_pkg::S_CHECK;
						default: state_d = eads_pkg::S_REPLY;
					endcase
				end
			end
			eads_pkg::S_CLEAR: begin
				if (stat.clr_last) begin
					state_d = reply_q ? eads_pkg::S_REPLY : eads_pkg::S_IDLE;
				end
			end
			eads_pkg::S_CHECK: begin
				if (stat.bad) begin
					status_d = eads_pkg::STAT_BAD;
					state_d = eads_pkg::S_REPLY;
				end else begin
					phase_d = 2'd0;
					load_next = 1'b1;
					state_d = eads_pkg::S_WALK;
				end
			end
			eads_pkg::S_WALK: begin
				if (stat.walk_root) begin
					state_d = eads_pkg::S_COMP;
				end
			end
			eads_pkg::S_COMP: begin
				if (stat.comp_done) begin
					if (op_q == eads_pkg::OP_DECLARE) begin
						if (!phase_q[0]) begin
							phase_d = phase_q + 2'd1;
							load_next = 1'b1;
							state_d = eads_pkg::S_WALK;
						end else if (!stat.roots_eq) begin
							state_d = eads_pkg::S_LINK1;
						end else if (phase_q == 2'd1) begin
							phase_d = 2'd2;
							load_next = 1'b1;
							state_d = eads_pkg::S_WALK;
						end else begin
							state_d = eads_pkg::S_REPLY;
						end
					end else begin
						if (phase_q == 2'd0) begin
							phase_d = 2'd1;
							load_next = 1'b1;
							state_d = eads_pkg::S_WALK;
						end else if (phase_q == 2'd1) begin
							if (stat.roots_eq) begin
								status_d = eads_pkg::STAT_SAME;
								state_d = eads_pkg::S_REPLY;
							end else begin
								phase_d = 2'd2;
								load_next = 1'b1;
								state_d = eads_pkg::S_WALK;
							end
						end else begin
							status_d = stat.roots_eq ? eads_pkg::STAT_DIFF
								: eads_pkg::STAT_UNSURE;
							state_d = eads_pkg::S_REPLY;
						end
					end
				end
			end
			eads_pkg::S_LINK1: state_d = eads_pkg::S_LINK2;
			eads_pkg::S_LINK2: state_d = eads_pkg::S_LNEXT;
			eads_pkg::S_LNEXT: begin
				if (phase_q == 2'd1) begin
					phase_d = 2'd2;
					load_next = 1'b1;
					state_d = eads_pkg::S_WALK;
				end else begin
					state_d = eads_pkg::S_REPLY;
				end
			end
			eads_pkg::S_REPLY: begin
				reply_d = 1'b0;
				state_d = eads_pkg::S_IDLE;
			end
			default: state_d = eads_pkg::S_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		busy = (state_q != eads_pkg::S_IDLE);
		done = (state_q == eads_pkg::S_REPLY);
		status = status_q;
		cmd.op = eads_pkg::DP_NOP;
		cmd.node = node_of(op_q, phase_q);
		cmd.save_ry = phase_q[0] || (op_q == eads_pkg::OP_ASK && phase_q != 2'd0);
		case (state_q)
			eads_pkg::S_IDLE: if (start) cmd.op = eads_pkg::DP_CAPTURE;
			eads_pkg::S_CLEAR: cmd.op = eads_pkg::DP_CLEAR;
			eads_pkg::S_WALK: cmd.op = stat.walk_root ? eads_pkg::DP_ROOT : eads_pkg::DP_FOLLOW;
			eads_pkg::S_COMP: if (!stat.comp_done) cmd.op = eads_pkg::DP_COMPRESS;
			eads_pkg::S_LINK1: cmd.op = eads_pkg::DP_LINK1;
			eads_pkg::S_LINK2: cmd.op = eads_pkg::DP_LINK2;
			default: ;
		endcase
		if (load_next) begin
			cmd.op = eads_pkg::DP_LOAD;
			cmd.node = node_of(op_q, phase_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eads_pkg::S_CLEAR;
			op_q <= eads_pkg::OP_CLEAR;
			status_q <= eads_pkg::STAT_DONE;
			phase_q <= 2'd0;
			reply_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			status_q <= status_d;
			phase_q <= phase_d;
			reply_q <= reply_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/enemy_aware_disjoint_set_top.sv -----
// Top level of the enemy-aware disjoint-set engine: configuration port and wiring.
// Depends on eads_pkg, eads_ctrl and eads_dp.
//
// This block keeps 2*MAX_PEOPLE union-find nodes in one on-chip memory: node p is
// person p and node p+n is the opposite group of p, with n the effective people
// count. A word is accepted when start is high and busy is low; exactly one result
// word follows, shown on status for one cycle with done high, and the receiver
// cannot hold it off. A clear word, and reset itself, sweep the whole memory one
// node per cycle (busy stays high meanwhile; reset gives no result). A declare
// word runs four root finds and up to two link updates, each through the states
// LINK1, LINK2 and LNEXT; an ask word runs two or three finds. Each find walks
// the parent chain at one memory read per cycle, then walks it again writing
// compressed links; union by rank keeps the trees shallow. The engine returns to
// idle after each result and can take the next word from there. A bad index is
// answered through the check state, with no find. The user must write
// people_count through the APB port at address 0 only while the block is idle;
// the block itself does not enforce it.
`default_nettype none
module enemy_aware_disjoint_set_top #(
	parameter int unsigned MAX_PEOPLE = eads_pkg::MaxPeopleDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] person_a,
	input  wire logic [15:0] person_b,
	output logic             done,
	output logic [2:0]       status
);
	logic [eads_pkg::CountW-1:0] people_count_q;
	eads_pkg::dp_cmd_t cmd;
	eads_pkg::dp_stat_t stat;

	// The only register sits at byte address 0; other addresses read as zero.
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? 32'(people_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			people_count_q <= eads_pkg::CountReset;
		end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
			people_count_q <= pwdata[eads_pkg::CountW-1:0];
		end
	end

	eads_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.done   (done),
		.status (status),
		.cmd    (cmd),
		.stat   (stat)
	);

	eads_dp #(
		.MAX_PEOPLE (MAX_PEOPLE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.person_a     (person_a),
		.person_b     (person_b),
		.people_count (people_count_q)
	);

endmodule
`default_nettype wire
